// ----- src/assert_macros.svh -----
// Assertion helpers for the XTEA block cipher.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/xtea_pkg.sv -----
// Shared types, constants and round-constant functions for the XTEA cipher.
// No dependencies.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int WORD_W     = 32;
  localparam int ROUNDS     = 32;
  localparam int STAGES     = 2 * ROUNDS;  // one half-round per pipeline stage
  localparam int NUM_KEYS   = 4;
  localparam int KEY_IDX_W  = 2;
  localparam int CFG_IDX_W  = 8;

  localparam logic [WORD_W-1:0] DELTA_NEG = 32'h61C8_8647;
  localparam logic [WORD_W-1:0] DELTA     = 32'h0 - DELTA_NEG;  // 0x9E3779B9

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } stage_t;

  // Running sum used by half-round k; n = number of delta steps taken so far.
  function automatic logic [WORD_W-1:0] enc_sum(input int k);
    logic [WORD_W-1:0] n_w;
    n_w = WORD_W'((k + 1) >> 1);
    return n_w * DELTA;
  endfunction

  function automatic logic [WORD_W-1:0] dec_sum(input int k);
    logic [WORD_W-1:0] n_w;
    n_w = WORD_W'(ROUNDS - ((k + 1) >> 1));
    return n_w * DELTA;
  endfunction

endpackage

// ----- src/xtea_key_regs.sv -----
// Key register file written through the configuration channel.
// Depends on xtea_pkg.
`timescale 1ns / 1ps

module xtea_key_regs
  import xtea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output key_t                 key
);

  key_t key_r;

  assign cfg_ready = 1'b1;
  assign key       = key_r;

  // writes to an index past the key words are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_KEYS))) begin
      key_r[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

endmodule

// ----- src/xtea_half_round.sv -----
// One XTEA half-round (update of one word) for either direction.
// Depends on xtea_pkg.
`timescale 1ns / 1ps

module xtea_half_round
  import xtea_pkg::*;
(
  input  logic              parity,
  input  logic [WORD_W-1:0] enc_sum_c,
  input  logic [WORD_W-1:0] dec_sum_c,
  input  key_t              key,
  input  stage_t            din,
  output stage_t            dout
);

  logic                 upd_v1;
  logic [WORD_W-1:0]    sum;
  logic [KEY_IDX_W-1:0] kidx;
  logic [WORD_W-1:0]    src;
  logic [WORD_W-1:0]    dst;
  logic [WORD_W-1:0]    mix;
  logic [WORD_W-1:0]    f;
  logic [WORD_W-1:0]    res;

  // encrypt even / decrypt odd update v0; the other two update v1
  assign upd_v1 = din.op ^ parity;
  assign sum    = (din.op == OP_DECRYPT) ? dec_sum_c : enc_sum_c;
  assign kidx   = upd_v1 ? sum[12:11] : sum[KEY_IDX_W-1:0];
  assign src    = upd_v1 ? din.v0 : din.v1;
  assign dst    = upd_v1 ? din.v1 : din.v0;
  assign mix    = ((src << 4) ^ (src >> 5)) + src;
  assign f      = mix ^ (sum + key[kidx]);
  assign res    = (din.op == OP_DECRYPT) ? (dst - f) : (dst + f);

  always_comb begin
    dout = din;
    if (upd_v1) begin
      dout.v1 = res;
    end else begin
      dout.v0 = res;
    end
  end

endmodule

// ----- src/xtea_out_buf.sv -----
// Output register with a skid entry; parts pipeline advance from out_tready.
// Depends on xtea_pkg.
`timescale 1ns / 1ps

module xtea_out_buf
  import xtea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  stage_t                push_data,
  output logic                  room,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*WORD_W-1:0]   out_tdata
);

  logic        out_vld_r;
  logic        skid_vld_r;
  stage_t      out_r;
  stage_t      skid_r;
  logic        pop;

  assign pop        = out_vld_r && out_tready;
  assign room       = !skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.v1, out_r.v0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // pipeline is held while the skid entry is full
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

// ----- src/xtea_block_cipher.sv -----
// XTEA block cipher, 64-bit block, 128-bit key from four config words.
// Fully pipelined: one half-round per stage, 64 stages, so a block enters every
// cycle while out_tready is held high; its result passes through the 64 stage
// registers and then the output register. The output register and its skid entry
// keep in_tready registered; it drops only when both are full. Keys are read
// live by every stage, so write them only while no block is in flight.
// Depends on xtea_pkg, xtea_key_regs, xtea_half_round, xtea_out_buf.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module xtea_block_cipher
  import xtea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*WORD_W-1:0]  in_tdata,   // [31:0] first_word, [63:32] second_word
  input  logic                 in_tuser,   // [0] operation (0 encrypt, 1 decrypt)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*WORD_W-1:0]  out_tdata,  // [31:0] out_first_word, [63:32] out_second_word
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  key_t              key;
  logic              adv;
  logic              buf_room;
  logic [STAGES-1:0] vld_r;
  stage_t            pay_r  [STAGES];
  stage_t            pay_in [STAGES];
  stage_t            pay_nxt[STAGES];

  xtea_key_regs u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign adv       = buf_room;
  assign in_tready = adv;

  assign pay_in[0] = '{op: in_tuser, v0: in_tdata[WORD_W-1:0], v1: in_tdata[2*WORD_W-1:WORD_W]};

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign pay_in[k] = pay_r[k-1];
    end

    xtea_half_round u_round (
      .parity    (1'(k % 2)),
      .enc_sum_c (enc_sum(k)),
      .dec_sum_c (dec_sum(k)),
      .key       (key),
      .din       (pay_in[k]),
      .dout      (pay_nxt[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        pay_r[k] <= pay_nxt[k];
      end
    end
  end

  xtea_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (adv && vld_r[STAGES-1]),
    .push_data  (pay_r[STAGES-1]),
    .room       (buf_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // skid entry is only ever filled behind a waiting output
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, !buf_room, out_tvalid)
  // a full buffer that is not drained keeps the input stalled
  `ASSERT_NEXT(a_full_holds, clk, rst_n, !buf_room && !out_tready, !in_tready && out_tvalid)
  // taken output with nothing behind it leaves the output empty
  `ASSERT_NEXT(a_drain_empty, clk, rst_n,
    out_tvalid && out_tready && buf_room && !vld_r[STAGES-1], !out_tvalid)

endmodule

// ----- dv/tb_xtea_block_cipher.sv -----
// Self-checking testbench for xtea_block_cipher: a directed table, then random phases with new keys.
// Every output block is checked against an XTEA computation in the bench itself.
// Depends on xtea_pkg and the xtea_block_cipher RTL.
`timescale 1ns / 1ps

module tb_xtea_block_cipher;
  import xtea_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_BLOCKS  = 75;
  localparam int RANDOM_PHASES = 6;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {ROW_BLOCK, ROW_KEY} row_kind_t;

  // ROW_BLOCK: op, first word, second word.  ROW_KEY: index, write data (op unused).
  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [2*WORD_W-1:0]  in_tdata;   // [31:0] first_word, [63:32] second_word
  logic                 in_tuser;   // [0] operation
  logic                 out_tvalid;
  logic                 out_tready;
  logic [2*WORD_W-1:0]  out_tdata;  // [31:0] out_first_word, [63:32] out_second_word
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  logic [WORD_W-1:0]   cipher_key [NUM_KEYS];
  logic [2*WORD_W-1:0] pending_blocks [$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  bit                  stall_on = 1'b1;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // zero key after reset
    '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLOCK, OP_DECRYPT, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLOCK, OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_BLOCK, OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000},
    // all-ones key
    '{ROW_KEY,   OP_ENCRYPT, 32'd0,         32'hFFFF_FFFF},
    '{ROW_KEY,   OP_ENCRYPT, 32'd1,         32'hFFFF_FFFF},
    '{ROW_KEY,   OP_ENCRYPT, 32'd2,         32'hFFFF_FFFF},
    '{ROW_KEY,   OP_ENCRYPT, 32'd3,         32'hFFFF_FFFF},
    '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLOCK, OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_BLOCK, OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
    '{ROW_BLOCK, OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
    // out-of-range indexes must leave the key alone
    '{ROW_KEY,   OP_ENCRYPT, 32'd4,         32'h1234_5678},
    '{ROW_KEY,   OP_ENCRYPT, 32'd255,       32'hDEAD_BEEF},
    '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
    '{ROW_KEY,   OP_ENCRYPT, 32'd0,         32'h0302_0100},
    '{ROW_KEY,   OP_ENCRYPT, 32'd1,         32'h0706_0504},
    '{ROW_KEY,   OP_ENCRYPT, 32'd2,         32'h0B0A_0908},
    '{ROW_KEY,   OP_ENCRYPT, 32'd3,         32'h0F0E_0D0C},
    '{ROW_BLOCK, OP_ENCRYPT, 32'h4443_4241, 32'h4847_4645},
    '{ROW_BLOCK, OP_DECRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A},
    // single key word change applies from the next block on
    '{ROW_KEY,   OP_ENCRYPT, 32'd2,         32'h0000_0000},
    '{ROW_BLOCK, OP_ENCRYPT, 32'h4443_4241, 32'h4847_4645},
    '{ROW_BLOCK, OP_DECRYPT, 32'h8000_0000, 32'h0000_0001}
  };

  xtea_block_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Full XTEA over ROUNDS rounds on one block with the current key; returns {second, first}.
  function automatic logic [2*WORD_W-1:0] xtea_block(input logic op,
                                                     input logic [WORD_W-1:0] w0,
                                                     input logic [WORD_W-1:0] w1);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    v0 = w0;
    v1 = w1;
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        v0  = v0 + (feistel_mix(v1) ^ (sum + cipher_key[sum[1:0]]));
        sum = sum + DELTA;
        v1  = v1 + (feistel_mix(v0) ^ (sum + cipher_key[sum[12:11]]));
      end
    end else begin
      sum = DELTA * WORD_W'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        v1  = v1 - (feistel_mix(v0) ^ (sum + cipher_key[sum[12:11]]));
        sum = sum - DELTA;
        v0  = v0 - (feistel_mix(v1) ^ (sum + cipher_key[sum[1:0]]));
      end
    end
    return {v1, v0};
  endfunction

  // Biased toward edge values so carries and bit extremes get hit often.
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] one_hot;
    one_hot = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  function automatic int draw_gap();
    return stall_on ? $urandom_range(0, 19) : 0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_block(input logic op, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {w1, w0};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Keys may only change with nothing in flight.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Scoreboard: key shadow, expectations on input items, checks on output items.
  always @(posedge clk) begin
    logic [2*WORD_W-1:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_KEYS)
        cipher_key[cfg_index] = cfg_data;
      if (in_tvalid && in_tready)
        pending_blocks.push_back(xtea_block(in_tuser, in_tdata[WORD_W-1:0],
                                            in_tdata[2*WORD_W-1:WORD_W]));
      if (out_tvalid && out_tready) begin
        if (pending_blocks.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected output item %h", out_tdata);
          error_count++;
        end else begin
          want = pending_blocks.pop_front();
          if (out_tdata[WORD_W-1:0] !== want[WORD_W-1:0]) begin
            if (error_count < MAX_REPORTS)
              $display("out_first_word: expected %h, got %h",
                       want[WORD_W-1:0], out_tdata[WORD_W-1:0]);
            error_count++;
          end
          if (out_tdata[2*WORD_W-1:WORD_W] !== want[2*WORD_W-1:WORD_W]) begin
            if (error_count < MAX_REPORTS)
              $display("out_second_word: expected %h, got %h",
                       want[2*WORD_W-1:WORD_W], out_tdata[2*WORD_W-1:WORD_W]);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_xtea_block_cipher failed");
      $finish;
    end
  end

  // Output side: random stall before each item, then hold ready until it is taken.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    logic                op;
    logic [WORD_W-1:0]   w0;
    logic [WORD_W-1:0]   w1;
    logic [2*WORD_W-1:0] prev_out;
    logic                prev_op;

    for (int k = 0; k < NUM_KEYS; k++) cipher_key[k] = '0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_ENCRYPT;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    prev_out  = '0;
    prev_op   = OP_ENCRYPT;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_KEY) begin
        if (in_tvalid) drain_pipeline();
        write_key(directed_rows[i].a[CFG_IDX_W-1:0], directed_rows[i].b);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_block(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pipeline();
      // a couple of phases run back to back on both sides
      stall_on = (phase != 2 && phase != 5);
      for (int k = 0; k < NUM_KEYS; k++) begin
        case (phase)
          0:       write_key(CFG_IDX_W'(k), '1);
          1:       write_key(CFG_IDX_W'(k), '0);
          default: write_key(CFG_IDX_W'(k), pick_word());
        endcase
      end
      if ($urandom_range(0, 1))
        write_key(CFG_IDX_W'($urandom_range(NUM_KEYS, 255)), $urandom);
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (n > 0 && $urandom_range(0, 3) == 0) begin
          // feed the last result back the other way
          op = ~prev_op;
          w0 = prev_out[WORD_W-1:0];
          w1 = prev_out[2*WORD_W-1:WORD_W];
        end else begin
          op = $urandom_range(0, 1);
          w0 = pick_word();
          w1 = pick_word();
        end
        prev_op  = op;
        prev_out = xtea_block(op, w0, w1);
        send_block(op, w0, w1);
      end
    end

    drain_pipeline();
    repeat (2 * STAGES) @(negedge clk);
    if (error_count == 0)
      $display("tb_xtea_block_cipher passed");
    else
      $display("tb_xtea_block_cipher failed");
    $finish;
  end

endmodule
